FILE: rtl/core/two_landmark_trilateration_assert.svh
// assertion macros used by the trilateration checker
`ifndef TWO_LANDMARK_TRILATERATION_ASSERT_SVH
`define TWO_LANDMARK_TRILATERATION_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define TLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ttri_pkg.sv
// shared widths, stage records and helpers of the trilateration pipeline
package ttri_pkg;

  // square root row: two radicand bits per cell
  localparam int unsigned SQ_STEPS  = 24;
  localparam int unsigned SQ_RAD_W  = 2 * SQ_STEPS;
  localparam int unsigned SQ_ROOT_W = SQ_STEPS;
  localparam int unsigned SQ_REM_W  = SQ_STEPS + 2;

  // divider row: one quotient bit per cell
  localparam int unsigned DV_STEPS = 25;
  localparam int unsigned DV_W     = 26;
  localparam int unsigned MAG_W    = DV_STEPS + DV_W;

  // clock edges from accept to the result strobe
  localparam int unsigned LAT = 4 + SQ_STEPS + DV_STEPS + 2 + SQ_STEPS + 3 + DV_STEPS + 2;

  localparam logic signed [26:0] POS_MAX = 27'sd8388607;
  localparam logic signed [26:0] POS_MIN = -27'sd8388608;

  // square root cell state
  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_RAD_W-1:0]  rad;
  } sq_t;

  // divider cell state
  typedef struct packed {
    logic [DV_W-1:0]     rem;
    logic [DV_STEPS-1:0] quo;
    logic [DV_W-1:0]     dvs;
  } dv_t;

  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [22:0]        r1;
    logic [22:0]        r2;
    logic [23:0]        rs;
    logic signed [23:0] rd;
  } s1_t;

  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [45:0]        r1sq;
    logic [45:0]        r2sq;
    logic [47:0]        rssq;
    logic [45:0]        rdsq;
    logic [49:0]        dx2;
    logic [49:0]        dy2;
  } s2_t;

  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [45:0]        r1sq;
    logic [49:0]        d2;
    logic [51:0]        num;
    logic               ok;
  } s3_t;

  // riding beside the distance root
  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [45:0]        r1sq;
    logic [MAG_W-1:0]   nmag;
    logic               nneg;
    logic               ok;
  } sbd_t;

  // riding beside the along-axis divider
  typedef struct packed {
    logic signed [23:0]   x1;
    logic signed [23:0]   y1;
    logic signed [24:0]   dx;
    logic signed [24:0]   dy;
    logic [45:0]          r1sq;
    logic [SQ_ROOT_W-1:0] d;
    logic                 nneg;
    logic                 ok;
  } sba_t;

  typedef struct packed {
    logic signed [23:0]   x1;
    logic signed [23:0]   y1;
    logic signed [24:0]   dx;
    logic signed [24:0]   dy;
    logic [45:0]          r1sq;
    logic signed [25:0]   a;
    logic [49:0]          asq;
    logic [SQ_ROOT_W-1:0] d;
    logic                 ok;
  } sa1_t;

  // riding beside the cross-axis root
  typedef struct packed {
    logic signed [23:0]   x1;
    logic signed [23:0]   y1;
    logic signed [24:0]   dx;
    logic signed [24:0]   dy;
    logic signed [25:0]   a;
    logic [SQ_ROOT_W-1:0] d;
    logic                 ok;
  } sbh_t;

  typedef struct packed {
    logic signed [23:0]   x1;
    logic signed [23:0]   y1;
    logic [SQ_ROOT_W-1:0] d;
    logic signed [50:0]   p1;
    logic signed [50:0]   p2;
    logic signed [50:0]   p3;
    logic signed [50:0]   p4;
    logic                 ok;
  } sb1_t;

  typedef struct packed {
    logic signed [23:0]   x1;
    logic signed [23:0]   y1;
    logic [SQ_ROOT_W-1:0] d;
    logic signed [51:0]   nx;
    logic signed [51:0]   ny;
    logic                 ok;
  } sb2_t;

  // riding beside the offset dividers
  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic               xneg;
    logic               yneg;
    logic               ok;
  } sbx_t;

  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [25:0] ox;
    logic signed [25:0] oy;
    logic               ok;
  } sc1_t;

  // clamp a widened coordinate sum to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[23:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/two_landmark_trilateration.sv
// top level: vehicle position from two landmarks and their ranges
//
//   channel   | handshake       | payload
//   ----------+-----------------+----------------------------------------------
//   command   | start_i, busy_o | first_x/y/range_i, second_x/y/range_i
//   result    | done_o strobe   | pos_x_o, pos_y_o, solvable_o
//
// fully pipelined: one beat accepted every cycle, busy_o stays low
// the path from the accepting edge to the result runs through two 24-cell root rows
//   and two 25-cell divider rows in series
//   (the x and y offset rows run side by side)
// reset clears only the valid chain; the data cells carry no reset
// results are shown for one cycle; the receiver has no back-pressure
module two_landmark_trilateration (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [23:0] first_x_i,
  input  logic signed [23:0] first_y_i,
  input  logic [22:0]        first_range_i,
  input  logic signed [23:0] second_x_i,
  input  logic signed [23:0] second_y_i,
  input  logic [22:0]        second_range_i,
  output logic               done_o,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic               solvable_o
);
  import ttri_pkg::*;

  logic           accept;
  logic [LAT-1:0] vld_q;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  sq_t  sq4_d, sq4_q;
  sbd_t sbd_d;
  sbd_t sbd_q [SQ_STEPS+1];
  sq_t  sqd_w [SQ_STEPS+1];

  dv_t  dva_w [DV_STEPS+1];
  sba_t sba_d;
  sba_t sba_q [DV_STEPS];

  sa1_t sa1_d, sa1_q;
  sq_t  sqh_d, sqh_q;
  sbh_t sbh_d;
  sbh_t sbh_q [SQ_STEPS+1];
  sq_t  sqh_w [SQ_STEPS+1];

  sb1_t sb1_d, sb1_q;
  sb2_t sb2_d, sb2_q;
  dv_t  dvx_d, dvx_q, dvy_d, dvy_q;
  sbx_t sbx_d;
  sbx_t sbx_q [DV_STEPS+1];
  dv_t  dvx_w [DV_STEPS+1];
  dv_t  dvy_w [DV_STEPS+1];

  sc1_t sc1_d, sc1_q;

  logic signed [49:0]  dx_w, dy_w;
  logic signed [45:0]  rd_w;
  logic [49:0]         d2_w;
  logic [51:0]         nabs_w;
  logic [DV_STEPS-1:0] amag_w;
  logic [50:0]         h2_w;
  logic signed [50:0]  a_b, dx_b, dy_b, h_b;
  logic [51:0]         xabs_w, yabs_w;
  logic signed [26:0]  sx_w, sy_w;
  logic signed [23:0]  pos_x_d, pos_x_q, pos_y_d, pos_y_q;
  logic                sol_d, sol_q;

  // never stalls
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // stage 1: differences, range sum and difference
  always_comb begin
    s1_d.x1 = first_x_i;
    s1_d.y1 = first_y_i;
    s1_d.dx = 25'(second_x_i) - 25'(first_x_i);
    s1_d.dy = 25'(second_y_i) - 25'(first_y_i);
    s1_d.r1 = first_range_i;
    s1_d.r2 = second_range_i;
    s1_d.rs = 24'(first_range_i) + 24'(second_range_i);
    s1_d.rd = 24'(first_range_i) - 24'(second_range_i);
  end

  // stage 2: squares
  always_comb begin
    dx_w      = 50'(s1_q.dx);
    dy_w      = 50'(s1_q.dy);
    rd_w      = 46'(s1_q.rd);
    s2_d.x1   = s1_q.x1;
    s2_d.y1   = s1_q.y1;
    s2_d.dx   = s1_q.dx;
    s2_d.dy   = s1_q.dy;
    s2_d.r1sq = 46'(s1_q.r1) * 46'(s1_q.r1);
    s2_d.r2sq = 46'(s1_q.r2) * 46'(s1_q.r2);
    s2_d.rssq = 48'(s1_q.rs) * 48'(s1_q.rs);
    s2_d.rdsq = rd_w * rd_w;
    s2_d.dx2  = dx_w * dx_w;
    s2_d.dy2  = dy_w * dy_w;
  end

  // stage 3: squared distance, numerator of a, meet test
  always_comb begin
    d2_w      = s2_q.dx2 + s2_q.dy2;
    s3_d.x1   = s2_q.x1;
    s3_d.y1   = s2_q.y1;
    s3_d.dx   = s2_q.dx;
    s3_d.dy   = s2_q.dy;
    s3_d.r1sq = s2_q.r1sq;
    s3_d.d2   = d2_w;
    s3_d.num  = 52'(s2_q.r1sq) - 52'(s2_q.r2sq) + 52'(d2_w);
    s3_d.ok   = (d2_w != '0) && (d2_w <= 50'(s2_q.rssq)) && (d2_w >= 50'(s2_q.rdsq));
  end

  // stage 4: numerator magnitude, root row entry
  always_comb begin
    nabs_w     = s3_q.num[51] ? (52'(0) - s3_q.num) : s3_q.num;
    sq4_d.rem  = '0;
    sq4_d.root = '0;
    sq4_d.rad  = s3_q.d2[SQ_RAD_W-1:0];
    sbd_d.x1   = s3_q.x1;
    sbd_d.y1   = s3_q.y1;
    sbd_d.dx   = s3_q.dx;
    sbd_d.dy   = s3_q.dy;
    sbd_d.r1sq = s3_q.r1sq;
    sbd_d.nmag = nabs_w[MAG_W-1:0];
    sbd_d.nneg = s3_q.num[51];
    sbd_d.ok   = s3_q.ok;
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    s3_q     <= s3_d;
    sq4_q    <= sq4_d;
    sbd_q[0] <= sbd_d;
    for (int i = 1; i <= SQ_STEPS; i++) begin
      sbd_q[i] <= sbd_q[i-1];
    end
  end

  // distance root row
  assign sqd_w[0] = sq4_q;
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqd
    ttri_sqrt_cell u_cell (
      .clk_i (clk_i),
      .sq_i  (sqd_w[g]),
      .sq_o  (sqd_w[g+1])
    );
  end

  // along-axis divider entry: |num| / (2d)
  always_comb begin
    dva_w[0].rem = sbd_q[SQ_STEPS].nmag[MAG_W-1 -: DV_W];
    dva_w[0].quo = sbd_q[SQ_STEPS].nmag[DV_STEPS-1:0];
    dva_w[0].dvs = DV_W'({sqd_w[SQ_STEPS].root, 1'b0});
    sba_d.x1     = sbd_q[SQ_STEPS].x1;
    sba_d.y1     = sbd_q[SQ_STEPS].y1;
    sba_d.dx     = sbd_q[SQ_STEPS].dx;
    sba_d.dy     = sbd_q[SQ_STEPS].dy;
    sba_d.r1sq   = sbd_q[SQ_STEPS].r1sq;
    sba_d.d      = sqd_w[SQ_STEPS].root;
    sba_d.nneg   = sbd_q[SQ_STEPS].nneg;
    sba_d.ok     = sbd_q[SQ_STEPS].ok;
  end

  for (genvar g = 0; g < DV_STEPS; g++) begin : g_dva
    ttri_div_cell u_cell (
      .clk_i (clk_i),
      .dv_i  (dva_w[g]),
      .dv_o  (dva_w[g+1])
    );
  end

  // signed a and a squared
  always_comb begin
    amag_w     = dva_w[DV_STEPS].quo;
    sa1_d.x1   = sba_q[DV_STEPS-1].x1;
    sa1_d.y1   = sba_q[DV_STEPS-1].y1;
    sa1_d.dx   = sba_q[DV_STEPS-1].dx;
    sa1_d.dy   = sba_q[DV_STEPS-1].dy;
    sa1_d.r1sq = sba_q[DV_STEPS-1].r1sq;
    sa1_d.a    = sba_q[DV_STEPS-1].nneg ? (26'(0) - 26'(amag_w)) : 26'(amag_w);
    sa1_d.asq  = 50'(amag_w) * 50'(amag_w);
    sa1_d.d    = sba_q[DV_STEPS-1].d;
    sa1_d.ok   = sba_q[DV_STEPS-1].ok;
  end

  // h squared, clamped at zero
  always_comb begin
    h2_w       = 51'(sa1_q.r1sq) - 51'(sa1_q.asq);
    sqh_d.rem  = '0;
    sqh_d.root = '0;
    sqh_d.rad  = h2_w[50] ? '0 : h2_w[SQ_RAD_W-1:0];
    sbh_d.x1   = sa1_q.x1;
    sbh_d.y1   = sa1_q.y1;
    sbh_d.dx   = sa1_q.dx;
    sbh_d.dy   = sa1_q.dy;
    sbh_d.a    = sa1_q.a;
    sbh_d.d    = sa1_q.d;
    sbh_d.ok   = sa1_q.ok;
  end

  always_ff @(posedge clk_i) begin
    sba_q[0] <= sba_d;
    for (int i = 1; i < DV_STEPS; i++) begin
      sba_q[i] <= sba_q[i-1];
    end
    sa1_q    <= sa1_d;
    sqh_q    <= sqh_d;
    sbh_q[0] <= sbh_d;
    for (int i = 1; i <= SQ_STEPS; i++) begin
      sbh_q[i] <= sbh_q[i-1];
    end
  end

  // cross-axis root row
  assign sqh_w[0] = sqh_q;
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqh
    ttri_sqrt_cell u_cell (
      .clk_i (clk_i),
      .sq_i  (sqh_w[g]),
      .sq_o  (sqh_w[g+1])
    );
  end

  // offset products
  always_comb begin
    a_b      = 51'(sbh_q[SQ_STEPS].a);
    dx_b     = 51'(sbh_q[SQ_STEPS].dx);
    dy_b     = 51'(sbh_q[SQ_STEPS].dy);
    h_b      = 51'(sqh_w[SQ_STEPS].root);
    sb1_d.x1 = sbh_q[SQ_STEPS].x1;
    sb1_d.y1 = sbh_q[SQ_STEPS].y1;
    sb1_d.d  = sbh_q[SQ_STEPS].d;
    sb1_d.p1 = a_b * dx_b;
    sb1_d.p2 = h_b * dy_b;
    sb1_d.p3 = a_b * dy_b;
    sb1_d.p4 = h_b * dx_b;
    sb1_d.ok = sbh_q[SQ_STEPS].ok;
  end

  // offset numerators
  always_comb begin
    sb2_d.x1 = sb1_q.x1;
    sb2_d.y1 = sb1_q.y1;
    sb2_d.d  = sb1_q.d;
    sb2_d.nx = 52'(sb1_q.p1) + 52'(sb1_q.p2);
    sb2_d.ny = 52'(sb1_q.p3) - 52'(sb1_q.p4);
    sb2_d.ok = sb1_q.ok;
  end

  // magnitudes into the offset divider rows
  always_comb begin
    xabs_w     = sb2_q.nx[51] ? (52'(0) - sb2_q.nx) : sb2_q.nx;
    yabs_w     = sb2_q.ny[51] ? (52'(0) - sb2_q.ny) : sb2_q.ny;
    dvx_d.rem  = xabs_w[MAG_W-1 -: DV_W];
    dvx_d.quo  = xabs_w[DV_STEPS-1:0];
    dvx_d.dvs  = DV_W'(sb2_q.d);
    dvy_d.rem  = yabs_w[MAG_W-1 -: DV_W];
    dvy_d.quo  = yabs_w[DV_STEPS-1:0];
    dvy_d.dvs  = DV_W'(sb2_q.d);
    sbx_d.x1   = sb2_q.x1;
    sbx_d.y1   = sb2_q.y1;
    sbx_d.xneg = sb2_q.nx[51];
    sbx_d.yneg = sb2_q.ny[51];
    sbx_d.ok   = sb2_q.ok;
  end

  always_ff @(posedge clk_i) begin
    sb1_q    <= sb1_d;
    sb2_q    <= sb2_d;
    dvx_q    <= dvx_d;
    dvy_q    <= dvy_d;
    sbx_q[0] <= sbx_d;
    for (int i = 1; i <= DV_STEPS; i++) begin
      sbx_q[i] <= sbx_q[i-1];
    end
  end

  // offset divider rows, x and y side by side
  assign dvx_w[0] = dvx_q;
  assign dvy_w[0] = dvy_q;
  for (genvar g = 0; g < DV_STEPS; g++) begin : g_dvxy
    ttri_div_cell u_cell_x (
      .clk_i (clk_i),
      .dv_i  (dvx_w[g]),
      .dv_o  (dvx_w[g+1])
    );
    ttri_div_cell u_cell_y (
      .clk_i (clk_i),
      .dv_i  (dvy_w[g]),
      .dv_o  (dvy_w[g+1])
    );
  end

  // signed offsets
  always_comb begin
    sc1_d.x1 = sbx_q[DV_STEPS].x1;
    sc1_d.y1 = sbx_q[DV_STEPS].y1;
    sc1_d.ox = sbx_q[DV_STEPS].xneg ? (26'(0) - 26'(dvx_w[DV_STEPS].quo))
                                    : 26'(dvx_w[DV_STEPS].quo);
    sc1_d.oy = sbx_q[DV_STEPS].yneg ? (26'(0) - 26'(dvy_w[DV_STEPS].quo))
                                    : 26'(dvy_w[DV_STEPS].quo);
    sc1_d.ok = sbx_q[DV_STEPS].ok;
  end

  // final sums, saturation, zero when unsolvable
  always_comb begin
    sx_w    = 27'(sc1_q.x1) + 27'(sc1_q.ox);
    sy_w    = 27'(sc1_q.y1) + 27'(sc1_q.oy);
    pos_x_d = sc1_q.ok ? sat24(sx_w) : '0;
    pos_y_d = sc1_q.ok ? sat24(sy_w) : '0;
    sol_d   = sc1_q.ok;
  end

  always_ff @(posedge clk_i) begin
    sc1_q   <= sc1_d;
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
    sol_q   <= sol_d;
  end

  // result beat
  assign done_o     = vld_q[LAT-1];
  assign pos_x_o    = pos_x_q;
  assign pos_y_o    = pos_y_q;
  assign solvable_o = vld_q[LAT-1] && sol_q;

endmodule

FILE: rtl/core/ttri_sqrt_cell.sv
// one digit-recurrence square root cell: two radicand bits, one root bit
module ttri_sqrt_cell (
  input  logic          clk_i,
  input  ttri_pkg::sq_t sq_i,
  output ttri_pkg::sq_t sq_o
);
  import ttri_pkg::*;

  logic [SQ_REM_W+1:0] part;
  logic [SQ_REM_W+1:0] trial;
  sq_t                 sq_d;
  sq_t                 sq_q;

  // trial subtract of 4*root+1
  always_comb begin
    part     = {sq_i.rem, sq_i.rad[SQ_RAD_W-1 -: 2]};
    trial    = {2'b00, sq_i.root, 2'b01};
    sq_d.rad = {sq_i.rad[SQ_RAD_W-3:0], 2'b00};
    if (part >= trial) begin
      sq_d.rem  = SQ_REM_W'(part - trial);
      sq_d.root = {sq_i.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      sq_d.rem  = part[SQ_REM_W-1:0];
      sq_d.root = {sq_i.root[SQ_ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

FILE: rtl/core/ttri_div_cell.sv
// one restoring divider cell: one quotient bit per cell
module ttri_div_cell (
  input  logic          clk_i,
  input  ttri_pkg::dv_t dv_i,
  output ttri_pkg::dv_t dv_o
);
  import ttri_pkg::*;

  logic [DV_W:0] part;
  logic [DV_W:0] dvs_w;
  dv_t           dv_d;
  dv_t           dv_q;

  // shift in the next dividend bit and try the divisor
  always_comb begin
    part     = {dv_i.rem, dv_i.quo[DV_STEPS-1]};
    dvs_w    = {1'b0, dv_i.dvs};
    dv_d.dvs = dv_i.dvs;
    if (part >= dvs_w) begin
      dv_d.rem = DV_W'(part - dvs_w);
      dv_d.quo = {dv_i.quo[DV_STEPS-2:0], 1'b1};
    end else begin
      dv_d.rem = part[DV_W-1:0];
      dv_d.quo = {dv_i.quo[DV_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  assign dv_o = dv_q;

endmodule

FILE: rtl/core/ttri_chk.sv
// port-level checks for the trilateration top, bound to every instance
`include "two_landmark_trilateration_assert.svh"

module ttri_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [23:0] first_x_i,
  input logic signed [23:0] first_y_i,
  input logic [22:0]        first_range_i,
  input logic signed [23:0] second_x_i,
  input logic signed [23:0] second_y_i,
  input logic [22:0]        second_range_i,
  input logic               done_o,
  input logic signed [23:0] pos_x_o,
  input logic signed [23:0] pos_y_o,
  input logic               solvable_o
);
  import ttri_pkg::*;

  logic acc;
  logic in_any;

  assign acc    = start_i && !busy_o;
  assign in_any = ^{first_x_i, first_y_i, first_range_i, second_x_i, second_y_i,
                    second_range_i};

  // every accepted beat comes out after the fixed latency
  `TLT_ASSERT_IMP(a_lat_out, clk_i, rst_ni, acc, ##LAT done_o, "accepted beat lost")
  // no result beat without a command beat the fixed latency earlier
  `TLT_ASSERT_IMP(a_no_spur, clk_i, rst_ni, done_o, $past(acc, LAT), "spurious result")
  // an unsolvable result carries a zero position
  `TLT_ASSERT_IMP(a_zero_pos, clk_i, rst_ni, done_o && !solvable_o,
                  pos_x_o == 24'sd0 && pos_y_o == 24'sd0, "nonzero unsolved position")
  // solvable flag only within a result beat
  `TLT_ASSERT_IMP(a_sol_beat, clk_i, rst_ni, solvable_o, done_o, "flag outside beat")
  // the command side is never held off
  `TLT_ASSERT_NEXT(a_no_busy, clk_i, rst_ni, in_any || !in_any, !busy_o, "busy raised")

endmodule

bind two_landmark_trilateration ttri_chk u_ttri_chk (.*);

FILE: bench/tb.sv
// self-checking bench for the two-landmark position solver
`timescale 1ns / 1ps

module tb;

  localparam int unsigned PIPE_LAT = 109;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic               ok;
  } fix_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [23:0] first_x_i = '0;
  logic signed [23:0] first_y_i = '0;
  logic [22:0]        first_range_i = '0;
  logic signed [23:0] second_x_i = '0;
  logic signed [23:0] second_y_i = '0;
  logic [22:0]        second_range_i = '0;
  logic               done_o;
  logic signed [23:0] pos_x_o;
  logic signed [23:0] pos_y_o;
  logic               solvable_o;

  fix_t fix_q[$];
  int   err_cnt = 0;
  int   beat_cnt = 0;
  int   fix_cnt = 0;
  int   solved_cnt = 0;
  bit   quiet = 1'b0;

  two_landmark_trilateration dut (.*);

  always #4 clk_i = ~clk_i;

  // exact integer square root, floor
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // circle-circle intersection in Q15.8
  function automatic fix_t solve_fix(input logic signed [23:0] x1, y1,
                                     input logic [22:0] r1,
                                     input logic signed [23:0] x2, y2,
                                     input logic [22:0] r2);
    fix_t f;
    longint dx, dy, d2, rs, rd, d, num, a, h2, h, ir1, ir2;
    f.px = '0;
    f.py = '0;
    f.ok = 1'b0;
    ir1 = longint'(r1);
    ir2 = longint'(r2);
    dx = longint'(x2) - longint'(x1);
    dy = longint'(y2) - longint'(y1);
    d2 = dx * dx + dy * dy;
    rs = ir1 + ir2;
    rd = ir1 - ir2;
    if (d2 == 0 || d2 > rs * rs || d2 < rd * rd) return f;
    d = longint'(int_sqrt(d2));
    num = ir1 * ir1 - ir2 * ir2 + d2;
    a = num / (2 * d);
    h2 = ir1 * ir1 - a * a;
    h = (h2 > 0) ? longint'(int_sqrt(h2)) : 0;
    f.px = clamp24(longint'(x1) + (a * dx + h * dy) / d);
    f.py = clamp24(longint'(y1) + (a * dy - h * dx) / d);
    f.ok = 1'b1;
    return f;
  endfunction

  // send one beat, with random idle cycles unless quiet
  task automatic send_pair(input logic signed [23:0] x1, y1, input logic [22:0] r1,
                           input logic signed [23:0] x2, y2, input logic [22:0] r2);
    while (!quiet && $urandom_range(99) < 10) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    first_x_i <= x1;
    first_y_i <= y1;
    first_range_i <= r1;
    second_x_i <= x2;
    second_y_i <= y2;
    second_range_i <= r2;
    do @(posedge clk_i); while (busy_o);
    fix_q.push_back(solve_fix(x1, y1, r1, x2, y2, r2));
    beat_cnt++;
  endtask

  task automatic pause_start();
    start_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    fix_t e;
    if (rst_ni && done_o) begin
      fix_cnt++;
      if (fix_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d ok=%0b", $realtime,
                 pos_x_o, pos_y_o, solvable_o);
        err_cnt++;
      end else begin
        e = fix_q.pop_front();
        if (solvable_o) solved_cnt++;
        if (e.ok !== solvable_o || e.px !== pos_x_o || e.py !== pos_y_o) begin
          $display("%0t: expected x=%0d y=%0d ok=%0b, got x=%0d y=%0d ok=%0b",
                   $realtime, e.px, e.py, e.ok, pos_x_o, pos_y_o, solvable_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_corners();
    send_pair(24'sd0, 24'sd0, 23'd0, 24'sd0, 24'sd0, 23'd0);             // coincident
    send_pair(24'sd100, 24'sd100, 23'd500, 24'sd100, 24'sd100, 23'd500); // coincident, ranges
    send_pair(24'sd0, 24'sd0, 23'd256, 24'sd512, 24'sd0, 23'd256);       // tangent outside
    send_pair(24'sd0, 24'sd0, 23'd768, 24'sd512, 24'sd0, 23'd256);       // tangent inside
    send_pair(24'sd0, 24'sd0, 23'd100, 24'sd2560, 24'sd0, 23'd100);      // too far apart
    send_pair(24'sd0, 24'sd0, 23'd5000, 24'sd100, 24'sd0, 23'd100);      // one inside other
    send_pair(24'sd0, 24'sd0, 23'd1280, 24'sd1536, 24'sd0, 23'd1280);    // normal
    send_pair(24'sd0, 24'sd0, 23'd1280, 24'sd0, 24'sd1536, 23'd1280);    // vertical axis
    send_pair(24'sh800000, 24'sh800000, 23'h7fffff,
              24'sh7fffff, 24'sh7fffff, 23'h7fffff);                     // extreme span
    send_pair(24'sh7fffff, 24'sh800000, 23'h7fffff,
              24'sh800000, 24'sh7fffff, 23'h7fffff);
    send_pair(24'sh7fffff, 24'sh7fffff, 23'h7fffff,
              24'sh7ffff0, 24'sh7fffff, 23'h7fffff);                     // saturates high
    send_pair(24'sh800000, 24'sh800000, 23'h7fffff,
              24'sh800010, 24'sh800000, 23'h7fffff);                     // saturates low
    send_pair(24'sd0, 24'sd0, 23'd3, 24'sd1, 24'sd1, 23'd3);             // rounding
    send_pair(24'sd0, 24'sd0, 23'd1, 24'sd2, 24'sd0, 23'd1);
    send_pair(-24'sd300, 24'sd700, 23'h7fffff, 24'sd300, -24'sd700, 23'h7ffff0);
    pause_start();
  endtask

  task automatic test_random(input int n);
    logic signed [23:0] x1, y1, x2, y2;
    logic [22:0] r1, r2, dd;
    int mode;
    repeat (n) begin
      mode = int'($urandom_range(9));
      x1 = 24'($urandom());
      y1 = 24'($urandom());
      if (mode < 3) begin
        // raw noise over the full ranges
        x2 = 24'($urandom());
        y2 = 24'($urandom());
        r1 = 23'($urandom());
        r2 = 23'($urandom());
      end else begin
        // nearby landmark and ranges that mostly make the circles meet
        x2 = x1 + $signed(24'($urandom_range(4000))) - 24'sd2000;
        y2 = y1 + $signed(24'($urandom_range(4000))) - 24'sd2000;
        dd = 23'($urandom_range(3000, 1));
        r1 = (mode == 9) ? 23'($urandom()) : 23'($urandom_range(4000) + dd / 2);
        r2 = 23'($urandom_range(4000) + dd / 2);
      end
      send_pair(x1, y1, r1, x2, y2, r2);
    end
    pause_start();
  endtask

  initial begin
    int wait_cnt;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_random(350);
    quiet = 1'b1;
    test_random(150);
    quiet = 1'b0;
    test_random(250);
    wait_cnt = 0;
    while (fix_q.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    $display("sent %0d beats, %0d results checked, %0d solvable", beat_cnt, fix_cnt,
             solved_cnt);
    if (err_cnt == 0 && fix_q.size() == 0) begin
      $display("[two_landmark_trilateration] OK");
    end else begin
      $display("[two_landmark_trilateration] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[two_landmark_trilateration] ERROR");
    $finish;
  end

endmodule
